@@ design/srtxt_pkg.sv @@
package srtxt_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int ALPHA_SLOTS = 16;
  localparam int RADIX_CAP   = (MAX_RADIX < ALPHA_SLOTS) ? MAX_RADIX : ALPHA_SLOTS;

  localparam int DATA_W    = 32;
  localparam int DIGIT_W   = 4;
  localparam int RADIX_W   = 5;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 64;
  localparam int INDEX_W   = 2;
  localparam int STEP_BITS = 8;
  localparam int DIV_STEPS = DATA_W / STEP_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PTR_W     = $clog2(DATA_W);
  localparam int ND_W      = PTR_W + 1;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [INDEX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } reg_index_t;

  typedef logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] alphabet_t;

  function automatic logic [RADIX_W-1:0] radix_in_use(input logic [RADIX_W-1:0] r);
    if (r > RADIX_W'(RADIX_CAP)) begin
      return RADIX_W'(RADIX_CAP);
    end
    return r;
  endfunction

endpackage

@@ design/srtxt_check.sv @@
module srtxt_check (
  input  srtxt_pkg::alphabet_t                alphabet,
  input  logic [srtxt_pkg::RADIX_W-1:0]       n,
  input  logic [srtxt_pkg::DIGIT_W-1:0]       idx,
  output logic                                bad
);

  logic [srtxt_pkg::CHAR_W-1:0] c;

  assign c = alphabet[idx];

  always_comb begin
    bad = (c == srtxt_pkg::CHAR_PLUS) || (c == srtxt_pkg::CHAR_MINUS);
    for (int j = 0; j < srtxt_pkg::ALPHA_SLOTS; j++) begin
      if ((srtxt_pkg::RADIX_W'(j) < n) && (srtxt_pkg::DIGIT_W'(j) > idx) &&
          (alphabet[j] == c)) begin
        bad = 1'b1;
      end
    end
  end

endmodule

@@ design/srtxt_div.sv @@
module srtxt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic [srtxt_pkg::DATA_W-1:0]       dividend,
  input  logic [srtxt_pkg::RADIX_W-1:0]      divisor,
  output logic                               done,
  output logic [srtxt_pkg::DATA_W-1:0]       quotient,
  output logic [srtxt_pkg::DIGIT_W-1:0]      remainder
);

  logic [srtxt_pkg::DATA_W-1:0]  work;
  logic [srtxt_pkg::DIGIT_W-1:0] rem;
  logic [srtxt_pkg::CNT_W-1:0]   cnt;
  logic                          active;

  logic [srtxt_pkg::DATA_W-1:0]  work_next;
  logic [srtxt_pkg::DIGIT_W-1:0] rem_next;
  logic [srtxt_pkg::RADIX_W-1:0] trial;

  always_comb begin
    work_next = work;
    rem_next  = rem;
    trial     = '0;
    for (int k = 0; k < srtxt_pkg::STEP_BITS; k++) begin
      trial     = {rem_next, work_next[srtxt_pkg::DATA_W-1]};
      work_next = {work_next[srtxt_pkg::DATA_W-2:0], 1'b0};
      if (trial >= divisor) begin
        trial        = trial - divisor;
        work_next[0] = 1'b1;
      end
      rem_next = trial[srtxt_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == srtxt_pkg::CNT_W'(srtxt_pkg::DIV_STEPS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      work <= dividend;
      rem  <= '0;
    end else if (active) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

@@ design/signed_int_to_radix_text.sv @@
// Converts a signed 32-bit value to text in the configured radix, one character per
// cycle on character/last under strobe, most significant digit first, with '-' ahead
// of a negative value. The receiver cannot stall: strobe pulses must be taken as they
// come. busy is high from the accepting edge until the final character has been
// registered. For each item, the n characters of the radix in use are first checked
// for a valid alphabet, one character per cycle; then a shared divider produces each
// digit, least significant first, 8 quotient bits per cycle; a negative value then
// gets its '-', and the stored digits are sent out in reverse. An invalid alphabet or
// a radix below 2 emits nothing. cfg_ready is always high; write the registers only
// while busy is low and no character is still pending.
module signed_int_to_radix_text (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [srtxt_pkg::DATA_W-1:0] value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srtxt_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [srtxt_pkg::CFG_W-1:0]         cfg_data,
  output logic                                strobe,
  output logic [srtxt_pkg::CHAR_W-1:0]        character,
  output logic                                last
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_DIVIDE = 5'b00100,
    S_SIGN   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [srtxt_pkg::RADIX_W-1:0] radix;
  logic [srtxt_pkg::CFG_W-1:0]   alphabet_low;
  logic [srtxt_pkg::CFG_W-1:0]   alphabet_high;
  srtxt_pkg::alphabet_t          alphabet;

  logic                          neg;
  logic [srtxt_pkg::DATA_W-1:0]  mag;
  logic [srtxt_pkg::RADIX_W-1:0] n;
  logic [srtxt_pkg::RADIX_W-1:0] n_last;
  logic [srtxt_pkg::DIGIT_W-1:0] idx;
  logic [srtxt_pkg::ND_W-1:0]    nd;
  logic [srtxt_pkg::PTR_W-1:0]   ptr;
  logic [srtxt_pkg::DIGIT_W-1:0] digits [srtxt_pkg::DATA_W];

  logic [srtxt_pkg::DATA_W-1:0]  value_u;
  logic                          accept;
  logic                          check_bad;
  logic                          div_go;
  logic [srtxt_pkg::DATA_W-1:0]  div_dividend;
  logic                          div_done;
  logic [srtxt_pkg::DATA_W-1:0]  div_quotient;
  logic [srtxt_pkg::DIGIT_W-1:0] div_remainder;

  assign alphabet  = {alphabet_high, alphabet_low};
  assign value_u   = unsigned'(value);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign n_last    = n - 1'b1;

  srtxt_check u_check (
    .alphabet (alphabet),
    .n        (n),
    .idx      (idx),
    .bad      (check_bad)
  );

  srtxt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (n),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_comb begin
    state_next   = state;
    div_go       = 1'b0;
    div_dividend = mag;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((n < srtxt_pkg::RADIX_W'(2)) || check_bad) begin
          state_next = S_IDLE;
        end else if ({1'b0, idx} == n_last) begin
          state_next = S_DIVIDE;
          div_go     = 1'b1;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          if (div_quotient == '0) begin
            state_next = neg ? S_SIGN : S_EMIT;
          end else begin
            div_go       = 1'b1;
            div_dividend = div_quotient;
          end
        end
      end
      S_SIGN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (ptr == '0) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      strobe        <= 1'b0;
      radix         <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_SIGN) || (state == S_EMIT);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srtxt_pkg::REG_RADIX:    radix         <= cfg_data[srtxt_pkg::RADIX_W-1:0];
          srtxt_pkg::REG_ALPHA_LO: alphabet_low  <= cfg_data;
          srtxt_pkg::REG_ALPHA_HI: alphabet_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value_u[srtxt_pkg::DATA_W-1];
      mag <= value_u[srtxt_pkg::DATA_W-1] ? (~value_u + 1'b1) : value_u;
      n   <= srtxt_pkg::radix_in_use(radix);
      idx <= '0;
      nd  <= '0;
    end
    if (state == S_CHECK) begin
      idx <= idx + 1'b1;
    end
    if ((state == S_DIVIDE) && div_done) begin
      digits[nd[srtxt_pkg::PTR_W-1:0]] <= div_remainder;
      nd  <= nd + 1'b1;
      ptr <= nd[srtxt_pkg::PTR_W-1:0];
    end
    if (state == S_SIGN) begin
      character <= srtxt_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end
    if (state == S_EMIT) begin
      character <= alphabet[digits[ptr]];
      last      <= (ptr == '0);
      ptr       <= ptr - 1'b1;
    end
  end

endmodule

@@ design/srtxt_chk.sv @@
module srtxt_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               strobe,
  input logic [srtxt_pkg::CHAR_W-1:0]       character,
  input logic                               last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == srtxt_pkg::CHAR_MINUS)) |-> !last)
    else $error("minus sign flagged as last character");

  a_text_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a value's text");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("character right after the last one");

  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    (strobe && $past(strobe) && !$past(last)) |-> (character != srtxt_pkg::CHAR_MINUS))
    else $error("minus sign inside digit sequence");

endmodule

bind signed_int_to_radix_text srtxt_chk u_srtxt_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [srtxt_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic signed [srtxt_pkg::DATA_W-1:0] value;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [srtxt_pkg::INDEX_W-1:0]       cfg_index;
  logic [srtxt_pkg::CFG_W-1:0]         cfg_data;
  logic                                strobe;
  logic [srtxt_pkg::CHAR_W-1:0]        character;
  logic                                last;

  logic signed [srtxt_pkg::DATA_W-1:0] value_q [$];
  text_char_t                          char_q [$];
  int                                  pending;
  int                                  idle_pct;
  int                                  err_count;

  logic [srtxt_pkg::RADIX_W-1:0]       radix_reg;
  srtxt_pkg::alphabet_t                alpha;

  signed_int_to_radix_text uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned radix_span(logic [srtxt_pkg::RADIX_W-1:0] r);
    int unsigned n;
    n = 32'(r);
    if (n > srtxt_pkg::MAX_RADIX) n = srtxt_pkg::MAX_RADIX;
    if (n > srtxt_pkg::ALPHA_SLOTS) n = srtxt_pkg::ALPHA_SLOTS;
    return n;
  endfunction

  function automatic bit alphabet_ok(int unsigned n, srtxt_pkg::alphabet_t a);
    if (n < 2) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (a[i] == srtxt_pkg::CHAR_PLUS || a[i] == srtxt_pkg::CHAR_MINUS) return 1'b0;
      for (int k = i + 1; k < n; k++) begin
        if (a[k] == a[i]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void render_text(logic signed [srtxt_pkg::DATA_W-1:0] v);
    int unsigned                    n;
    logic [srtxt_pkg::DATA_W-1:0]   mag;
    logic [srtxt_pkg::DIGIT_W-1:0]  digs [srtxt_pkg::DATA_W];
    int                             nd;
    n = radix_span(radix_reg);
    if (!alphabet_ok(n, alpha)) return;
    mag = v;
    if (v[srtxt_pkg::DATA_W-1]) mag = ~mag + 32'd1;
    nd = 0;
    do begin
      digs[nd] = srtxt_pkg::DIGIT_W'(mag % n);
      mag = mag / n;
      nd++;
    end while (mag != 0 && nd < srtxt_pkg::DATA_W);
    if (v[srtxt_pkg::DATA_W-1]) char_q.push_back(text_char_t'{srtxt_pkg::CHAR_MINUS, 1'b0});
    for (int i = nd - 1; i >= 0; i--) begin
      char_q.push_back(text_char_t'{alpha[digs[i]], i == 0});
    end
  endfunction

  function automatic srtxt_pkg::alphabet_t text_alphabet(string s);
    srtxt_pkg::alphabet_t a;
    a = '0;
    for (int i = 0; i < s.len() && i < srtxt_pkg::ALPHA_SLOTS; i++) a[i] = s[i];
    return a;
  endfunction

  function automatic srtxt_pkg::alphabet_t random_alphabet();
    srtxt_pkg::alphabet_t         a;
    logic [srtxt_pkg::CHAR_W-1:0] c;
    bit                           clash;
    a = '0;
    for (int i = 0; i < srtxt_pkg::ALPHA_SLOTS; i++) begin
      do begin
        c = srtxt_pkg::CHAR_W'($urandom_range(255));
        clash = (c == srtxt_pkg::CHAR_PLUS) || (c == srtxt_pkg::CHAR_MINUS);
        for (int k = 0; k < i; k++) begin
          if (a[k] == c) clash = 1'b1;
        end
      end while (clash);
      a[i] = c;
    end
    return a;
  endfunction

  function automatic logic signed [srtxt_pkg::DATA_W-1:0] random_value();
    logic [srtxt_pkg::DATA_W-1:0] m;
    int sel;
    sel = int'($urandom_range(99));
    if (sel < 50) return $urandom;
    if (sel < 75) begin
      m = $urandom_range(300);
    end else if (sel < 90) begin
      m = $urandom >> $urandom_range(31);
    end else begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic write_reg(srtxt_pkg::reg_index_t idx, logic [srtxt_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      srtxt_pkg::REG_RADIX:    radix_reg = data[srtxt_pkg::RADIX_W-1:0];
      srtxt_pkg::REG_ALPHA_LO: alpha[7:0] = data;
      srtxt_pkg::REG_ALPHA_HI: alpha[15:8] = data;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [srtxt_pkg::CFG_W-1:0] rdx, srtxt_pkg::alphabet_t a);
    write_reg(srtxt_pkg::REG_RADIX, rdx);
    write_reg(srtxt_pkg::REG_ALPHA_LO, a[7:0]);
    write_reg(srtxt_pkg::REG_ALPHA_HI, a[15:8]);
  endtask

  task automatic send(logic signed [srtxt_pkg::DATA_W-1:0] v);
    value_q.push_back(v);
    pending++;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending != 0 || busy || char_q.size() != 0);
    repeat (250) @(posedge clk);
  endtask

  // driver: hold start until accepted, then advance or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      value <= '0;
    end else begin
      if (start && !busy) begin
        render_text(value);
        pending--;
      end
      if (!(start && busy)) begin
        if (value_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          value <= value_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && strobe) begin
      if (char_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected character %h last %b", character, last));
      end else begin
        want = char_q.pop_front();
        if (character !== want.code)
          flag_mismatch($sformatf("character %h, want %h", character, want.code));
        if (last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", last, want.last));
      end
    end
  end

  initial begin
    srtxt_pkg::alphabet_t          a;
    logic [srtxt_pkg::CFG_W-1:0]   rdx;
    int idle_plan [4];
    int item_count;
    int phase;
    int n;
    int rin;
    int pos;
    int j;

    idle_plan = '{0, 56, 0, 20};
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = srtxt_pkg::REG_RADIX;
    cfg_data = '0;
    pending = 0;
    err_count = 0;
    idle_pct = 20;
    radix_reg = '0;
    alpha = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: radix zero, nothing comes out
    send(0);
    send(-5);
    drain();

    apply_config(64'd10, text_alphabet("0123456789"));
    send(32'sh8000_0000);
    send(32'sh7FFF_FFFF);
    send(0);
    send(-1);
    send(1);
    send(-10);
    send(1000000000);
    drain();

    apply_config(64'd16, text_alphabet("0123456789ABCDEF"));
    send(32'sh8000_0000);
    send(-1);
    send(32'sh7FFF_FFFF);
    drain();

    apply_config(64'd2, text_alphabet("01"));
    send(32'sh8000_0000);
    send(32'sh7FFF_FFFF);
    send(-1);
    drain();

    // oversize radix clamps to the alphabet size
    apply_config(64'd31, text_alphabet("0123456789ABCDEF"));
    send(255);
    drain();

    apply_config(64'd1, text_alphabet("0123456789"));
    send(5);
    drain();

    a = text_alphabet("0123456789");
    a[3] = srtxt_pkg::CHAR_PLUS;
    apply_config(64'd10, a);
    send(1);
    drain();

    a = text_alphabet("0123456789ABCDEF");
    a[15] = srtxt_pkg::CHAR_MINUS;
    apply_config(64'd16, a);
    send(7);
    drain();
    // same alphabet, minus sign now outside the digits in use
    apply_config(64'd15, a);
    send(-1000);
    drain();

    a = text_alphabet("0123456789");
    a[9] = a[2];
    apply_config(64'd10, a);
    send(12);
    drain();

    // zero byte as digit zero
    a = '0;
    for (int i = 0; i < 8; i++) a[i] = srtxt_pkg::CHAR_W'(i);
    apply_config(64'd8, a);
    send(8);
    send(-64);
    drain();

    apply_config(64'd16, '1);
    send(3);
    drain();

    item_count = 0;
    phase = 0;
    while (item_count < 430) begin
      idle_pct = idle_plan[phase % 4];
      a = random_alphabet();
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < 10; i++) a[i] = srtxt_pkg::CHAR_W'("0" + i);
      end
      rdx = {$urandom, $urandom};
      rdx[srtxt_pkg::RADIX_W-1:0] = ($urandom_range(9) == 0)
          ? srtxt_pkg::RADIX_W'($urandom_range(17, 31))
          : srtxt_pkg::RADIX_W'($urandom_range(2, 16));
      if ($urandom_range(99) < 20) begin
        rin = int'(radix_span(rdx[srtxt_pkg::RADIX_W-1:0]));
        case ($urandom_range(2))
          0: rdx[srtxt_pkg::RADIX_W-1:0] = srtxt_pkg::RADIX_W'($urandom_range(1));
          1: a[$urandom_range(rin - 1)] = $urandom_range(1) ? srtxt_pkg::CHAR_PLUS
                                                            : srtxt_pkg::CHAR_MINUS;
          default: begin
            pos = int'($urandom_range(rin - 1));
            j = (pos + int'($urandom_range(1, rin - 1))) % rin;
            a[j] = a[pos];
          end
        endcase
      end
      apply_config(rdx, a);
      n = int'($urandom_range(10, 40));
      repeat (n) send(random_value());
      item_count += n;
      drain();
      phase++;
    end

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
design/srtxt_pkg.sv
design/srtxt_check.sv
design/srtxt_div.sv
design/signed_int_to_radix_text.sv
design/srtxt_chk.sv
tb/tb_top.sv
